// ----- sv/udiv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// udiv_pkg
// Types and constants shared by the 128-bit unsigned restoring divider.
// ----------------------------------------------------------------------------
package udiv_pkg;

    localparam int OPERAND_WIDTH_DEF = 128;
    localparam int HALF_W            = 64;

    typedef struct packed {
        logic [HALF_W-1:0] dividend_hi;
        logic [HALF_W-1:0] dividend_lo;
        logic [HALF_W-1:0] divisor_hi;
        logic [HALF_W-1:0] divisor_lo;
    } udiv_in_t;

    typedef struct packed {
        logic [HALF_W-1:0] quotient_hi;
        logic [HALF_W-1:0] quotient_lo;
        logic [HALF_W-1:0] remainder_hi;
        logic [HALF_W-1:0] remainder_lo;
        logic              zero_divisor;
    } udiv_out_t;

    // top -> core
    typedef struct packed {
        logic start;
        logic take;
    } udiv_ctl_t;

    // core -> top
    typedef struct packed {
        logic idle;
        logic done;
    } udiv_stat_t;

endpackage
`default_nettype wire

// ----- sv/unsigned_divider_128.sv -----
// From an input transfer to result valid: k divisor normalization shifts
// (k is 0 .. OPERAND_WIDTH-1), then one quotient bit per step; a zero divisor
// skips both phases. The result register is held while rsp_stall is asserted.
// A new input is taken only once the previous result has moved to the result
// register, as the single shared compare/subtract unit serves one division.
// Reset: asynchronous, active low; clears sequencer state and the output valid.
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_divider_128
// Unsigned restoring divider with registered result and valid/stall channels.
// ----------------------------------------------------------------------------
module unsigned_divider_128 #(
    parameter int OPERAND_WIDTH = udiv_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire udiv_pkg::udiv_in_t  req_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output udiv_pkg::udiv_out_t      rsp_data
);

    import udiv_pkg::*;

    udiv_ctl_t  ctl;
    udiv_stat_t stat;
    udiv_out_t  core_result;

    logic      rsp_valid_reg, rsp_valid_next;
    udiv_out_t rsp_data_reg;
    logic      out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !stat.idle;
    assign ctl.start = req_valid && stat.idle;
    assign ctl.take  = stat.done && out_free;

    udiv_core #(.W(OPERAND_WIDTH)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .operands (req_data),
        .stat     (stat),
        .result   (core_result)
    );

    // result register: refilled when empty or its transfer completes
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            rsp_data_reg <= core_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
`default_nettype wire

// ----- sv/udiv_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// udiv_alu
// Shared compare/subtract unit: a - b and the a >= b flag from one borrow chain.
// ----------------------------------------------------------------------------
module udiv_alu #(
    parameter int W = 128
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              ge,
    output logic [W-1:0]      diff
);

    logic [W:0] sub_w;

    assign sub_w = {1'b0, a} - {1'b0, b};
    assign ge    = ~sub_w[W];
    assign diff  = sub_w[W-1:0];

endmodule
`default_nettype wire

// ----- sv/udiv_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// udiv_core
// Sequencer and operand registers: normalize the divisor, then one quotient
// bit per cycle through the shared compare/subtract unit.
// ----------------------------------------------------------------------------
module udiv_core #(
    parameter int W = 128
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire udiv_pkg::udiv_ctl_t  ctl,
    input  wire udiv_pkg::udiv_in_t   operands,
    output udiv_pkg::udiv_stat_t      stat,
    output udiv_pkg::udiv_out_t       result
);

    import udiv_pkg::*;

    localparam int CW = $clog2(W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          zero_reg, zero_next;

    logic [2*HALF_W-1:0] dvd_full;
    logic [2*HALF_W-1:0] dvs_full;
    logic [W-1:0]        dvd_clip;
    logic [W-1:0]        dvs_clip;
    logic                alu_ge;
    logic [W-1:0]        alu_diff;
    logic [2*HALF_W-1:0] q_ext;
    logic [2*HALF_W-1:0] r_ext;

    assign dvd_full = {operands.dividend_hi, operands.dividend_lo};
    assign dvs_full = {operands.divisor_hi, operands.divisor_lo};
    assign dvd_clip = dvd_full[W-1:0];
    assign dvs_clip = dvs_full[W-1:0];

    udiv_alu #(.W(W)) u_alu (
        .a    (n_reg),
        .b    (d_reg),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    d_next   = dvs_clip;
                    q_next   = '0;
                    cnt_next = '0;
                    if (dvs_clip == '0)
                    begin
                        n_next     = '0;
                        zero_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        n_next     = dvd_clip;
                        zero_next  = 1'b0;
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (alu_ge && !d_reg[W-1])
                begin
                    d_next   = {d_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (alu_ge)
                begin
                    n_next = alu_diff;
                end
                q_next = {q_reg[W-2:0], alu_ge};
                d_next = {1'b0, d_reg[W-1:1]};
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
    end

    assign q_ext = (2*HALF_W)'(q_reg);
    assign r_ext = (2*HALF_W)'(n_reg);

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

    assign result.quotient_hi  = q_ext[2*HALF_W-1:HALF_W];
    assign result.quotient_lo  = q_ext[HALF_W-1:0];
    assign result.remainder_hi = r_ext[2*HALF_W-1:HALF_W];
    assign result.remainder_lo = r_ext[HALF_W-1:0];
    assign result.zero_divisor = zero_reg;

endmodule
`default_nettype wire
